// ===== rtl/life_generation_stencil_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Life generation stencil unit
// Shared helpers that write clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STENCIL_UNIT_MACROS_SVH
`define LIFE_GENERATION_STENCIL_UNIT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define LGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define LGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// Life generation stencil package
// Shared constants and types of the bit-packed B3/S23 stencil unit.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int MAX_ROW_BYTES = 256;
  localparam int MAX_ROWS      = 1024;

  localparam int CELL_W      = 8;
  localparam int GROUPS_W    = 9;
  localparam int COUNT_W     = 11;
  localparam int CFG_W       = 11;
  localparam int ROW_FIELD_W = 10;
  localparam int COL_FIELD_W = 8;
  localparam int WIN_SIZE    = 9;
  localparam int MIN_DIM     = 3;

  localparam logic [GROUPS_W-1:0] GROUPS_RESET = GROUPS_W'(256);
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(1024);

  typedef enum logic {
    REG_ROW_GROUPS = 1'b0,
    REG_ROW_COUNT  = 1'b1
  } cfg_reg_e;

  typedef logic [CELL_W-1:0] cell_byte_t;
  typedef cell_byte_t [WIN_SIZE-1:0] window_t;

endpackage

// ===== rtl/lgs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lgs_stencil.sv =====
// ----------------------------------------------------------------------------
// Life stencil kernel
// Next-generation byte of the middle window byte under rule B3/S23.
// ----------------------------------------------------------------------------
module lgs_stencil (
  input  lgs_pkg::window_t   win_i,
  output lgs_pkg::cell_byte_t cells_o
);

  logic [9:0] line_a;
  logic [9:0] line_b;
  logic [9:0] line_c;
  logic [3:0] nbr [8];

  assign line_a = {win_i[0][0], win_i[1], win_i[2][7]};
  assign line_b = {win_i[3][0], win_i[4], win_i[5][7]};
  assign line_c = {win_i[6][0], win_i[7], win_i[8][7]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      nbr[i] = 4'(line_a[i]) + 4'(line_a[i+1]) + 4'(line_a[i+2])
             + 4'(line_b[i]) + 4'(line_b[i+2])
             + 4'(line_c[i]) + 4'(line_c[i+1]) + 4'(line_c[i+2]);
      cells_o[i] = (nbr[i] == 4'd3) || ((nbr[i] == 4'd2) && line_b[i+1]);
    end
  end

endmodule

// ===== rtl/life_generation_stencil_unit.sv =====
// ----------------------------------------------------------------------------
// Life generation stencil unit
// One B3/S23 generation over a bit-packed world streamed in raster order.
// ----------------------------------------------------------------------------
// The world enters one byte per transaction, ghost border included, and the
// unit sustains one byte per clock while the receiver keeps up. The
// next-generation byte of an interior position is produced when the byte one
// row below and one column to its right is accepted, and it becomes valid when
// that staged byte advances: the line-buffer read is registered together with
// the input byte at the accepting edge, and the advance loads the result
// register. A result that the receiver has not taken holds the staged byte and
// stalls the input. Ghost bytes are taken as zero and produce no transaction.
// A configuration write restarts the generation at row zero, column zero.
module life_generation_stencil_unit #(
  parameter int MAX_ROW_BYTES = lgs_pkg::MAX_ROW_BYTES,
  parameter int MAX_ROWS      = lgs_pkg::MAX_ROWS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [lgs_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lgs_pkg::CELL_W-1:0]        cells_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lgs_pkg::CELL_W-1:0]        new_cells_o,
  output logic [lgs_pkg::ROW_FIELD_W-1:0]   out_row_o,
  output logic [lgs_pkg::COL_FIELD_W-1:0]   out_col_o,
  output logic                              last_o
);

`include "life_generation_stencil_unit_macros.svh"

  localparam int COL_W = $clog2(MAX_ROW_BYTES);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int LINE_W = 2 * lgs_pkg::CELL_W;

  typedef struct packed {
    lgs_pkg::cell_byte_t                cells;
    logic                               emit;
    logic                               last;
    logic [lgs_pkg::ROW_FIELD_W-1:0]    row;
    logic [lgs_pkg::COL_FIELD_W-1:0]    col;
  } stage_t;

  logic [lgs_pkg::GROUPS_W-1:0] row_groups_q;
  logic [lgs_pkg::COUNT_W-1:0]  row_count_q;
  logic [COL_W-1:0]             last_col;
  logic [ROW_W-1:0]             last_row;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic              in_acc;
  logic              adv;
  logic              ghost;
  stage_t            stage_d, stage_q;
  logic              stage_valid_q;
  logic [COL_W-1:0]  stage_addr_q;

  logic [LINE_W-1:0]   line_rdata;
  logic [LINE_W-1:0]   line_wdata;
  lgs_pkg::window_t    win_q, win_d;
  lgs_pkg::cell_byte_t next_cells;

  logic                            out_valid_q, out_valid_d;
  lgs_pkg::cell_byte_t             out_cells_q;
  logic [lgs_pkg::ROW_FIELD_W-1:0] out_row_q;
  logic [lgs_pkg::COL_FIELD_W-1:0] out_col_q;
  logic                            out_last_q;

  always_comb begin
    priority if (row_groups_q < lgs_pkg::GROUPS_W'(lgs_pkg::MIN_DIM)) begin
      last_col = COL_W'(lgs_pkg::MIN_DIM - 1);
    end else if (32'(row_groups_q) > MAX_ROW_BYTES) begin
      last_col = COL_W'(MAX_ROW_BYTES - 1);
    end else begin
      last_col = COL_W'(row_groups_q - lgs_pkg::GROUPS_W'(1));
    end
    priority if (row_count_q < lgs_pkg::COUNT_W'(lgs_pkg::MIN_DIM)) begin
      last_row = ROW_W'(lgs_pkg::MIN_DIM - 1);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(row_count_q - lgs_pkg::COUNT_W'(1));
    end
  end

  assign adv        = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign ghost = (row_q == '0) || (row_q >= last_row) || (col_q == '0) || (col_q >= last_col);

  always_comb begin
    stage_d.cells = ghost ? '0 : cells_i;
    stage_d.emit  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
    stage_d.last  = (row_q >= last_row) && (col_q >= last_col);
    stage_d.row   = lgs_pkg::ROW_FIELD_W'(row_q - ROW_W'(1));
    stage_d.col   = lgs_pkg::COL_FIELD_W'(col_q - COL_W'(1));
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_q >= last_col) begin
        col_d = '0;
        row_d = (row_q >= last_row) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  lgs_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (stage_addr_q),
    .wdata_i (line_wdata),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  // Upper line in the high byte, middle line in the low byte.
  assign line_wdata = {line_rdata[lgs_pkg::CELL_W-1:0], stage_q.cells};

  always_comb begin
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = line_rdata[LINE_W-1:lgs_pkg::CELL_W];
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = line_rdata[lgs_pkg::CELL_W-1:0];
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = stage_q.cells;
  end

  lgs_stencil u_stencil (
    .win_i   (win_d),
    .cells_o (next_cells)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (adv) begin
      out_valid_d = stage_q.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_groups_q  <= lgs_pkg::GROUPS_RESET;
      row_count_q   <= lgs_pkg::COUNT_RESET;
      col_q         <= '0;
      row_q         <= '0;
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      win_q         <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        stage_valid_q <= 1'b1;
      end else if (adv) begin
        stage_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (lgs_pkg::cfg_reg_e'(cfg_idx_i))
          lgs_pkg::REG_ROW_GROUPS: row_groups_q <= cfg_wdata_i[lgs_pkg::GROUPS_W-1:0];
          lgs_pkg::REG_ROW_COUNT:  row_count_q  <= cfg_wdata_i[lgs_pkg::COUNT_W-1:0];
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
        win_q <= '0;
      end else begin
        col_q <= col_d;
        row_q <= row_d;
        if (adv) begin
          win_q <= win_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stage_q      <= stage_d;
      stage_addr_q <= col_q;
    end
    if (adv && stage_q.emit) begin
      out_cells_q <= next_cells;
      out_row_q   <= stage_q.row;
      out_col_q   <= stage_q.col;
      out_last_q  <= stage_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_cells_o = out_cells_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign last_o      = out_last_q;

  `LGS_ASSERT_NXT(a_emit_reaches_output, adv && stage_q.emit, out_valid_q, "emitting stage item lost")
  `LGS_ASSERT_IMP(a_position_in_range, 1'b1, (col_q <= last_col) && (row_q <= last_row), "position out of range")
  `LGS_ASSERT_IMP(a_stall_blocks_input, stage_valid_q && !adv, !in_ready_o, "input taken over stalled stage")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Life generation stencil unit testbench
// Streams bit-packed worlds through the unit under several world sizes and
// handshake patterns. Expected next-generation bytes come from a cycle-free
// model of the line buffers, the neighborhood window and the B3/S23 rule.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    lgs_pkg::cell_byte_t               cells;
    logic [lgs_pkg::ROW_FIELD_W-1:0]   row;
    logic [lgs_pkg::COL_FIELD_W-1:0]   col;
    logic                              last;
  } gen_byte_t;

  logic                              clk_i;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_we_i    = 1'b0;
  logic                              cfg_idx_i   = 1'b0;
  logic [lgs_pkg::CFG_W-1:0]         cfg_wdata_i = '0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_ready_o;
  logic [lgs_pkg::CELL_W-1:0]        cells_i     = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [lgs_pkg::CELL_W-1:0]        new_cells_o;
  logic [lgs_pkg::ROW_FIELD_W-1:0]   out_row_o;
  logic [lgs_pkg::COL_FIELD_W-1:0]   out_col_o;
  logic                              last_o;

  lgs_pkg::cell_byte_t world_bytes[$];
  gen_byte_t           due_bytes[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_requests  = 0;
  int          holds_served   = 0;
  int          hold_left      = 0;
  int          mismatches     = 0;

  logic [lgs_pkg::GROUPS_W-1:0] width_reg = lgs_pkg::GROUPS_RESET;
  logic [lgs_pkg::COUNT_W-1:0]  height_reg = lgs_pkg::COUNT_RESET;
  lgs_pkg::cell_byte_t          two_up_row[lgs_pkg::MAX_ROW_BYTES];
  lgs_pkg::cell_byte_t          one_up_row[lgs_pkg::MAX_ROW_BYTES];
  lgs_pkg::cell_byte_t          nbhd[lgs_pkg::WIN_SIZE] = '{default: '0};
  int                           at_row = 0;
  int                           at_col = 0;

  life_generation_stencil_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cells_i     (cells_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .new_cells_o (new_cells_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int clamp_dim(int v, int hi);
    if (v < lgs_pkg::MIN_DIM) return lgs_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic lgs_pkg::cell_byte_t apply_rule(logic [9:0] above, logic [9:0] here,
                                                     logic [9:0] below);
    lgs_pkg::cell_byte_t res;
    int                  n;
    res = '0;
    for (int i = 0; i < lgs_pkg::CELL_W; i++) begin
      n = int'(above[i]) + int'(above[i+1]) + int'(above[i+2])
        + int'(here[i]) + int'(here[i+2])
        + int'(below[i]) + int'(below[i+1]) + int'(below[i+2]);
      res[i] = (n == 3) || (n == 2 && here[i+1]);
    end
    return res;
  endfunction

  function automatic void set_register(lgs_pkg::cfg_reg_e idx,
                                       logic [lgs_pkg::CFG_W-1:0] val);
    if (idx == lgs_pkg::REG_ROW_GROUPS) begin
      width_reg = val[lgs_pkg::GROUPS_W-1:0];
    end else begin
      height_reg = val[lgs_pkg::COUNT_W-1:0];
    end
    at_row = 0;
    at_col = 0;
    foreach (nbhd[i]) nbhd[i] = '0;
  endfunction

  function automatic void predict_byte(lgs_pkg::cell_byte_t cells);
    int                  cols;
    int                  rows;
    lgs_pkg::cell_byte_t v;
    lgs_pkg::cell_byte_t up;
    lgs_pkg::cell_byte_t mid;
    gen_byte_t           res;
    cols = clamp_dim(int'(width_reg), lgs_pkg::MAX_ROW_BYTES);
    rows = clamp_dim(int'(height_reg), lgs_pkg::MAX_ROWS);
    v = cells;
    if (at_row == 0 || at_row >= rows - 1 || at_col == 0 || at_col >= cols - 1) begin
      v = '0;
    end
    up = two_up_row[at_col];
    mid = one_up_row[at_col];
    two_up_row[at_col] = mid;
    one_up_row[at_col] = v;
    nbhd[0] = nbhd[1]; nbhd[1] = nbhd[2]; nbhd[2] = up;
    nbhd[3] = nbhd[4]; nbhd[4] = nbhd[5]; nbhd[5] = mid;
    nbhd[6] = nbhd[7]; nbhd[7] = nbhd[8]; nbhd[8] = v;
    if (at_row >= 2 && at_col >= 2) begin
      res.cells = apply_rule({nbhd[0][0], nbhd[1], nbhd[2][7]},
                             {nbhd[3][0], nbhd[4], nbhd[5][7]},
                             {nbhd[6][0], nbhd[7], nbhd[8][7]});
      res.row = lgs_pkg::ROW_FIELD_W'(at_row - 1);
      res.col = lgs_pkg::COL_FIELD_W'(at_col - 1);
      res.last = (at_row >= rows - 1) && (at_col >= cols - 1);
      due_bytes.push_back(res);
    end
    if (at_col + 1 >= cols) begin
      at_col = 0;
      at_row = (at_row + 1 >= rows) ? 0 : at_row + 1;
    end else begin
      at_col = at_col + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cells_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (world_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        cells_i <= world_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
    end else if (holds_served < hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    gen_byte_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_bytes.size() == 0) begin
          $error("unexpected transaction: row %0d col %0d cells %h",
                 out_row_o, out_col_o, new_cells_o);
          mismatches++;
        end else begin
          want = due_bytes.pop_front();
          if (new_cells_o !== want.cells) begin
            $error("new_cells: expected %h, actual %h", want.cells, new_cells_o);
            mismatches++;
          end
          if (out_row_o !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, out_row_o);
            mismatches++;
          end
          if (out_col_o !== want.col) begin
            $error("out_col: expected %0d, actual %0d", want.col, out_col_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_byte(cells_i);
      end
    end
  end

  task automatic wait_drained();
    while (world_bytes.size() != 0 || in_valid_i || due_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(lgs_pkg::cfg_reg_e idx, logic [lgs_pkg::CFG_W-1:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    set_register(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_world(int count);
    int                  style;
    lgs_pkg::cell_byte_t b;
    style = 0;
    for (int k = 0; k < count; k++) begin
      if (k % 16 == 0) style = $urandom_range(0, 3);
      case (style)
        0: b = 8'($urandom);
        1: b = 8'($urandom & $urandom);
        2: b = 8'($urandom | $urandom);
        default: begin
          b = 8'h01 << $urandom_range(0, 7);
        end
      endcase
      world_bytes.push_back(b);
    end
  endtask

  task automatic run_world(logic [lgs_pkg::CFG_W-1:0] width_val,
                           logic [lgs_pkg::CFG_W-1:0] height_val,
                           int unsigned send_pct, int unsigned stall_pct, int count);
    write_reg(lgs_pkg::REG_ROW_GROUPS, width_val);
    write_reg(lgs_pkg::REG_ROW_COUNT, height_val);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    queue_world(count);
  endtask

  initial begin
    lgs_pkg::cell_byte_t shapes[9];
    shapes = '{8'h55, 8'hAA, 8'h33, 8'hCC, 8'h7E, 8'h81, 8'h0F, 8'hF0, 8'hE0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sizes below the minimum clamp to a single interior byte surrounded by ghosts.
    write_reg(lgs_pkg::REG_ROW_GROUPS, 11'd0);
    write_reg(lgs_pkg::REG_ROW_COUNT, 11'd1);
    repeat (9) world_bytes.push_back(8'hFF);
    world_bytes.push_back(8'h01);
    world_bytes.push_back(8'h80);
    world_bytes.push_back(8'hFF);
    world_bytes.push_back(8'h00);
    write_reg(lgs_pkg::REG_ROW_COUNT, 11'd3);
    foreach (shapes[i]) world_bytes.push_back(shapes[i]);

    run_world(11'd4, 11'd5, 0, 0, 160);
    hold_requests = hold_requests + 1;
    run_world(11'd7, 11'd6, 88, 0, 168);
    run_world(11'h405, 11'd12, 0, 88, 120);
    run_world(11'd12, 11'd4, 26, 26, 144);
    run_world(11'd300, 11'd2, 26, 26, 768);
    run_world(11'd1, 11'd2047, 26, 26, 36);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
